>>> rtl/core/sbfp_pkg.sv
package sbfp_pkg;

    // Lane geometry and frame limits.
    localparam int LANES           = 8;
    localparam int MAX_FRAME_BYTES = 65536;

    // Widths of the frame counter and per-beat lane counts.
    localparam int FC_W          = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LANE_CNT_W    = $clog2(LANES + 1);
    localparam int FLAGS_W       = 16;
    localparam int FRAME_BYTES_W = 17;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [LANES-1:0] lane_mask_t;

    // One classified beat: the lanes that become bytes plus the closing data.
    typedef struct packed {
        logic [63:0]              data;
        lane_mask_t               mask;
        logic                     last;
        logic [FLAGS_W-1:0]       flags;
        logic                     err;
        logic [FRAME_BYTES_W-1:0] bytes;
        logic                     ovf;
    } entry_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0]               byte_value;
        logic                     byte_present;
        logic                     frame_end;
        logic [FLAGS_W-1:0]       frame_flags;
        logic                     frame_err;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
        logic                     overflow;
        logic                     run_last;
    } res_t;

endpackage

>>> rtl/core/sbfp_front.sv
module sbfp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [63:0]      beat_data,
    input  logic [7:0]       beat_keep,
    input  logic [63:0]      beat_user,
    input  logic             beat_last,
    output logic             q_push,
    output sbfp_pkg::entry_t q_entry,
    input  logic             q_full
);
    import sbfp_pkg::*;

    logic [FC_W-1:0]       fc_reg;
    logic [FC_W-1:0]       fc_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [7:0]            first_user_reg;
    logic [7:0]            first_user_next;
    logic [7:0]            last_user_reg;
    logic [7:0]            last_user_next;
    logic                  ssi_mode_reg;
    logic [FC_W-1:0]       room;
    logic [LANE_CNT_W-1:0] kept_cnt;
    logic [LANE_CNT_W-1:0] emit_cnt;
    lane_mask_t            keep_eff;
    lane_mask_t            emit_mask;
    logic                  accept;

    assign accept = push && !q_full;
    assign full   = q_full;

    // Classify the lanes: which kept bytes still fit the frame, and the tracked user bytes.
    always_comb
    begin
        keep_eff       = beat_keep[LANES-1:0];
        room           = FC_W'(MAX_FRAME_BYTES) - fc_reg;
        kept_cnt       = '0;
        emit_cnt       = '0;
        emit_mask      = '0;
        last_user_next = last_user_reg;
        for (int x = 0; x < LANES; x++)
        begin
            if (keep_eff[x])
            begin
                if (FC_W'(kept_cnt) < room)
                begin
                    emit_mask[x] = 1'b1;
                    emit_cnt     = emit_cnt + LANE_CNT_W'(1);
                end
                kept_cnt       = kept_cnt + LANE_CNT_W'(1);
                last_user_next = beat_user[x*8 +: 8];
            end
        end
        first_user_next = (fc_reg == '0) ? beat_user[7:0] : first_user_reg;
        fc_next         = fc_reg + FC_W'(emit_cnt);
        ovf_next        = ovf_reg || (FC_W'(kept_cnt) > room);
    end

    // Build the queue entry; a beat with no byte and no frame end produces none.
    always_comb
    begin
        q_entry.data  = beat_data;
        q_entry.mask  = emit_mask;
        q_entry.last  = beat_last;
        q_entry.flags = ssi_mode_reg ? {last_user_next, first_user_next} : '0;
        q_entry.err   = ssi_mode_reg && last_user_next[0];
        q_entry.bytes = FRAME_BYTES_W'(fc_next);
        q_entry.ovf   = ovf_next;
        q_push        = accept && ((emit_mask != '0) || beat_last);
    end

    // Frame state advances on every accepted beat and clears when the frame closes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg         <= '0;
            ovf_reg        <= 1'b0;
            first_user_reg <= '0;
            last_user_reg  <= '0;
        end
        else if (accept)
        begin
            fc_reg         <= beat_last ? '0 : fc_next;
            ovf_reg        <= beat_last ? 1'b0 : ovf_next;
            first_user_reg <= first_user_next;
            last_user_reg  <= last_user_next;
        end
    end

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssi_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            ssi_mode_reg <= cfg_wdata;
        end
    end

    // The frame counter never passes the frame capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_W'(MAX_FRAME_BYTES))
        else $error("frame counter exceeds capacity");

    // Once bytes were dropped, the frame is full until it closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (fc_reg == FC_W'(MAX_FRAME_BYTES)))
        else $error("overflow flagged while frame has room");

endmodule

>>> rtl/core/sbfp_queue.sv
module sbfp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sbfp_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sbfp_pkg::entry_t head
);
    import sbfp_pkg::*;

    entry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // The fill count stays within the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

>>> rtl/core/sbfp_back.sv
module sbfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  sbfp_pkg::entry_t head,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output sbfp_pkg::res_t   res
);
    import sbfp_pkg::*;

    logic       out_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic       busy_reg;
    lane_mask_t cur_mask_reg;
    lane_mask_t mask_eff;
    lane_mask_t sel;
    lane_mask_t remaining;
    logic       final_beat;
    logic       load;

    // Work on the remaining lanes of the head entry, lowest lane first.
    always_comb
    begin
        mask_eff   = busy_reg ? cur_mask_reg : head.mask;
        sel        = mask_eff & (~mask_eff + LANES'(1));
        remaining  = mask_eff & (mask_eff - LANES'(1));
        final_beat = (remaining == '0);
        load       = head_valid && (!out_valid_reg || pop);
        q_pop      = load && final_beat;
    end

    // Form the next result; the closing data rides only on the frame's last result.
    always_comb
    begin
        res_next = '0;
        for (int x = 0; x < LANES; x++)
        begin
            if (sel[x])
            begin
                res_next.byte_value = head.data[x*8 +: 8];
            end
        end
        res_next.byte_present = (mask_eff != '0);
        res_next.frame_end    = final_beat && head.last;
        res_next.run_last     = final_beat;
        if (final_beat && head.last)
        begin
            res_next.frame_flags = head.flags;
            res_next.frame_err   = head.err;
            res_next.frame_bytes = head.bytes;
            res_next.overflow    = head.ovf;
        end
    end

    // Output register and lane tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= !final_beat;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload and remaining lane mask.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg      <= res_next;
            cur_mask_reg <= remaining;
        end
    end

    assign empty = !out_valid_reg;
    assign res   = res_reg;

    // A partly emitted entry is still at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> head_valid)
        else $error("lane tracking without a head entry");

    // A partly emitted entry always has lanes left.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_mask_reg != '0))
        else $error("busy with an empty lane mask");

endmodule

>>> rtl/core/stream_beat_to_frame_packer.sv
// Stream beat to frame packer. Each accepted beat has its kept byte lanes
// compacted low lane first into one result per byte; the last beat of a frame
// closes it on its final result (or on one byte-less result if it yields no
// byte), which carries the frame byte count, the overflow mark and, when
// ssi_mode is set, the first and last user bytes as flags and error. Bytes past
// the frame capacity are dropped and reported through overflow. The front end
// takes one beat per cycle while its two-entry queue has room; the back end
// emits one result per cycle from its output register while that register is
// empty or popped, so a beat with n bytes yields n results, a last beat without
// bytes one result, and a beat that yields no result never enters the queue. An
// accepted beat is written into the queue, and its first result is registered
// in the output register once the beat reaches the head of the queue.
module stream_beat_to_frame_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [63:0] beat_data,
    input  logic [7:0]  beat_keep,
    input  logic [63:0] beat_user,
    input  logic        beat_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  byte_value,
    output logic        byte_present,
    output logic        frame_end,
    output logic [15:0] frame_flags,
    output logic        frame_err,
    output logic [16:0] frame_bytes,
    output logic        overflow,
    output logic        run_last
);
    import sbfp_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   head_valid;
    entry_t push_entry;
    entry_t head;
    res_t   res;

    // Front end: classifies beats and tracks frame state.
    sbfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .beat_data (beat_data),
        .beat_keep (beat_keep),
        .beat_user (beat_user),
        .beat_last (beat_last),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .q_full    (q_full)
    );

    // Queue between the front and back ends.
    sbfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: emits one result per cycle while its output register is empty or popped.
    sbfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign byte_value   = res.byte_value;
    assign byte_present = res.byte_present;
    assign frame_end    = res.frame_end;
    assign frame_flags  = res.frame_flags;
    assign frame_err    = res.frame_err;
    assign frame_bytes  = res.frame_bytes;
    assign overflow     = res.overflow;
    assign run_last     = res.run_last;

endmodule
